FILE: hw/rtl/sha256_block_compression_top_defines.svh
// ============================================================================
// SHA-256 block compression assertion macros
// Shared assertion shorthands for the SHA-256 compression block.
// ============================================================================
`ifndef SHA256_BLOCK_COMPRESSION_TOP_DEFINES_SVH
`define SHA256_BLOCK_COMPRESSION_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SHA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SHA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/sha256_bc_pkg.sv
// ============================================================================
// SHA-256 block compression package
// Shared types, controller commands, round constants and initial hash value.
// ============================================================================
package sha256_bc_pkg;

   typedef logic [31:0] word_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_ROUND,
      ST_FINISH,
      ST_EMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load_word;
      logic       reload_iv;
      logic       init_work;
      logic       round_en;
      logic       add_en;
      logic [5:0] round_idx;
      logic [2:0] emit_idx;
   } cmd_type;

   localparam int NumRounds = 64;
   localparam int BlockWords = 16;

   localparam word_type SHA_IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   function automatic word_type round_k(input logic [5:0] idx);
      word_type k;
      unique case (idx)
         6'd0:  k = 32'h428a2f98;
         6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf;
         6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b;
         6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4;
         6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98;
         6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be;
         6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74;
         6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7;
         6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1;
         6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6;
         6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f;
         6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc;
         6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152;
         6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8;
         6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3;
         6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351;
         6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85;
         6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc;
         6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354;
         6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e;
         6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1;
         6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70;
         6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819;
         6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585;
         6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116;
         6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c;
         6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3;
         6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f;
         6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee;
         6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814;
         6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa;
         6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7;
         6'd63: k = 32'hc67178f2;
      endcase
      return k;
   endfunction

   function automatic word_type big_sigma0(input word_type x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

endpackage

FILE: hw/rtl/sha256_bc_ctrl.sv
// ============================================================================
// SHA-256 block compression controller
// Sequences word loading, the 64 rounds, the feed-forward add and digest output.
// ============================================================================
module sha256_bc_ctrl
   import sha256_bc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  logic    req_first_block,
   input  logic    req_final_block,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output logic    rsp_last_word,
   output cmd_type cmd
);

   state_type  state_ff,    state_in;
   logic [3:0] word_cnt_ff, word_cnt_in;
   logic [5:0] round_ff,    round_in;
   logic [2:0] emit_ff,     emit_in;
   logic       final_ff,    final_in;
   logic       accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         word_cnt_ff <= '0;
         round_ff    <= '0;
         emit_ff     <= '0;
         final_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         word_cnt_ff <= word_cnt_in;
         round_ff    <= round_in;
         emit_ff     <= emit_in;
         final_ff    <= final_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      word_cnt_in   = word_cnt_ff;
      round_in      = round_ff;
      emit_in       = emit_ff;
      final_in      = final_ff;
      req_stall     = (state_ff != ST_LOAD);
      rsp_valid     = (state_ff == ST_EMIT);
      rsp_last_word = (emit_ff == 3'd7);
      accept        = req_valid && !req_stall;

      cmd           = '0;
      cmd.round_idx = round_ff;
      cmd.emit_idx  = emit_ff;

      unique case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               cmd.load_word = 1'b1;
               word_cnt_in   = word_cnt_ff + 4'd1;
               // Only the flags on the first word of a block count.
               if (word_cnt_ff == 4'd0) begin
                  final_in      = req_final_block;
                  cmd.reload_iv = req_first_block;
               end
               if (word_cnt_ff == 4'd15) begin
                  cmd.init_work = 1'b1;
                  round_in      = '0;
                  state_in      = ST_ROUND;
               end
            end
         end
         ST_ROUND: begin
            cmd.round_en = 1'b1;
            round_in     = round_ff + 6'd1;
            if (round_ff == 6'(NumRounds - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.add_en = 1'b1;
            emit_in    = '0;
            state_in   = final_ff ? ST_EMIT : ST_LOAD;
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               emit_in = emit_ff + 3'd1;
               if (emit_ff == 3'd7) begin
                  state_in = ST_LOAD;
               end
            end
         end
      endcase
   end

endmodule

FILE: hw/rtl/sha256_bc_dp.sv
// ============================================================================
// SHA-256 block compression datapath
// Message schedule window, working variables, round logic and chaining value.
// ============================================================================
module sha256_bc_dp
   import sha256_bc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cmd_type  cmd,
   input  word_type req_message_word,
   output word_type rsp_digest_word
);

   word_type h_ff [8];
   word_type v_ff [8];
   word_type w_ff [BlockWords];
   word_type w_new;
   word_type t1;
   word_type t2;
   word_type choose;
   word_type major;

   // Schedule window: w_ff[0] is the word for the current round.
   assign w_new = small_sigma1(w_ff[14]) + w_ff[9] + small_sigma0(w_ff[1]) + w_ff[0];

   assign choose = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
   assign major  = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
   assign t1     = v_ff[7] + big_sigma1(v_ff[4]) + choose + round_k(cmd.round_idx) + w_ff[0];
   assign t2     = big_sigma0(v_ff[0]) + major;

   assign rsp_digest_word = h_ff[cmd.emit_idx];

   always_ff @(posedge clock) begin
      if (cmd.load_word || cmd.round_en) begin
         for (int i = 0; i < BlockWords - 1; i++) begin
            w_ff[i] <= w_ff[i + 1];
         end
         w_ff[BlockWords - 1] <= cmd.load_word ? req_message_word : w_new;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.init_work) begin
         v_ff <= h_ff;
      end else if (cmd.round_en) begin
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.reload_iv) begin
         h_ff <= SHA_IV;
      end else if (cmd.add_en) begin
         for (int i = 0; i < 8; i++) begin
            h_ff[i] <= h_ff[i] + v_ff[i];
         end
      end
   end

endmodule

FILE: hw/rtl/sha256_block_compression_top.sv
// ============================================================================
// SHA-256 block compression top level
// Streams 16-word padded blocks in and chaining words out after final blocks.
// ============================================================================
// Words are taken while loading; the sixteenth word starts 64 rounds at one per cycle.
// Each block goes through loading, rounds and add on the single shared round unit.
// After a final block the rounds and the feed-forward add run before the first digest
// word is offered; the eight words then follow one per cycle while rsp_stall is low.
// Input stalls from the sixteenth word to the add, or to the end of a final digest.
// Synchronous reset loads the initial hash value and clears the word counter.
module sha256_block_compression_top
   import sha256_bc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_message_word,
   input  logic        req_first_block,
   input  logic        req_final_block,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

`include "sha256_block_compression_top_defines.svh"

   cmd_type cmd;

   // The controller owns all counters and the state machine; it issues one
   // command word per cycle that tells the datapath what to update.
   sha256_bc_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_first_block (req_first_block),
      .req_final_block (req_final_block),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_last_word   (rsp_last_word),
      .cmd             (cmd)
   );

   // The datapath holds the schedule window, the working variables and the
   // chaining value; digest words are read straight out of the chaining registers,
   // which stay still while a digest word waits to be taken.
   sha256_bc_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_message_word (req_message_word),
      .rsp_digest_word  (rsp_digest_word)
   );

   assign rsp_word_index = cmd.emit_idx;

   // No message word is taken while a digest is being emitted.
   `SHA_ASSERT_IMP(a_no_input_in_emit, clock, reset, rsp_valid, req_stall,
      "input accepted while digest emitted")

   // A digest burst runs through all eight words before it ends.
   `SHA_ASSERT_NXT(a_burst_continues, clock, reset,
      rsp_valid && !rsp_stall && !rsp_last_word, rsp_valid,
      "digest burst ended early")

   // Word positions step by one on each taken digest word.
   `SHA_ASSERT_NXT(a_index_steps, clock, reset,
      rsp_valid && !rsp_stall && !rsp_last_word,
      rsp_word_index == ($past(rsp_word_index) + 3'd1),
      "digest word index skipped")

   // A burst only ends right after its last word.
   `SHA_ASSERT_IMP(a_end_after_last, clock, reset, $fell(rsp_valid), $past(rsp_last_word),
      "digest burst ended without last word")

endmodule

FILE: verif/sha256_block_compression_top_tb.sv
// ============================================================================
// SHA-256 block compression testbench
// Streams padded message words into the compression block and checks every
// digest word it returns against a cycle-free SHA-256 model kept in the
// bench. A known single-block message opens the run, random messages follow.
// ============================================================================
module sha256_block_compression_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sha256_bc_pkg::word_type;

   // One digest word as it appears on the result channel.
   typedef struct packed {
      logic [31:0] digest;
      logic [2:0]  index;
      logic        last_flag;
   } digest_out_type;

   // One row of the directed table. When known is set, the row completes a
   // final block whose digest is the published test vector below.
   typedef struct packed {
      logic [31:0] data;
      logic        first;
      logic        fin;
      logic        known;
   } stim_row_type;

   localparam int TOTAL_WORDS  = 320;
   localparam int PAUSE_BLOCK  = 10;  // sender drains the block before this one
   localparam int LONG_HOLD    = 300; // cycles of continuous result stall
   localparam int DRAIN_CYCLES = 100; // room for one block plus the digest
   localparam int STALL_LIMIT  = 3000;

   localparam word_type START_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // Digest of the three-byte message "abc", the standard one-block vector.
   localparam word_type ABC_DIGEST [8] = '{
      32'hba7816bf, 32'h8f01cfea, 32'h414140de, 32'h5dae2223,
      32'hb00361a3, 32'h96177a9c, 32'hb410ff61, 32'hf20015ad
   };

   // The first sixteen rows are the padded "abc" block. Its flags are set
   // on word 0 only; the odd flags on words 1 to 15 must be ignored, or the
   // known digest would not come out. The last eight rows open a second
   // final block of all-ones words without a reload, so it chains from the
   // "abc" digest; the random part finishes that block.
   localparam stim_row_type DIRECTED_ROWS [24] = '{
      '{32'h61626380, 1'b1, 1'b1, 1'b0},
      '{32'h00000000, 1'b1, 1'b0, 1'b0},
      '{32'h00000000, 1'b0, 1'b0, 1'b0},
      '{32'h00000000, 1'b1, 1'b1, 1'b0},
      '{32'h00000000, 1'b0, 1'b1, 1'b0},
      '{32'h00000000, 1'b1, 1'b0, 1'b0},
      '{32'h00000000, 1'b0, 1'b0, 1'b0},
      '{32'h00000000, 1'b1, 1'b1, 1'b0},
      '{32'h00000000, 1'b0, 1'b0, 1'b0},
      '{32'h00000000, 1'b0, 1'b1, 1'b0},
      '{32'h00000000, 1'b1, 1'b0, 1'b0},
      '{32'h00000000, 1'b0, 1'b0, 1'b0},
      '{32'h00000000, 1'b1, 1'b1, 1'b0},
      '{32'h00000000, 1'b0, 1'b0, 1'b0},
      '{32'h00000000, 1'b1, 1'b0, 1'b0},
      '{32'h00000018, 1'b1, 1'b0, 1'b1},
      '{32'hffffffff, 1'b0, 1'b1, 1'b0},
      '{32'hffffffff, 1'b1, 1'b0, 1'b0},
      '{32'hffffffff, 1'b0, 1'b0, 1'b0},
      '{32'hffffffff, 1'b1, 1'b1, 1'b0},
      '{32'hffffffff, 1'b0, 1'b0, 1'b0},
      '{32'hffffffff, 1'b1, 1'b0, 1'b0},
      '{32'hffffffff, 1'b0, 1'b1, 1'b0},
      '{32'hffffffff, 1'b1, 1'b1, 1'b0}
   };

   // Every input of the block holds a known value from time zero.
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_message_word = '0;
   logic        req_first_block = 1'b0;
   logic        req_final_block = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   // Model state: chaining words, the block being collected, and the flags
   // latched from its first word (bit 0 first, bit 1 final).
   word_type    chain_state [8];
   word_type    block_words [16];
   logic [3:0]  word_pos;
   logic [1:0]  block_mode;

   digest_out_type digest_expect_q [$];
   int          error_count = 0;
   int          words_accepted = 0;
   int          results_checked = 0;
   int          digests_seen = 0;
   int          digests_expected = 0;
   int          idle_cycles = 0;
   int          hold_left = 0;
   bit          long_hold_done = 1'b0;
   bit          steady_phase = 1'b0; // no idling on either side while set

   sha256_block_compression_top DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_message_word (req_message_word),
      .req_first_block  (req_first_block),
      .req_final_block  (req_final_block),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_digest_word  (rsp_digest_word),
      .rsp_word_index   (rsp_word_index),
      .rsp_last_word    (rsp_last_word)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic word_type rotr(input word_type x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // Expands the schedule of the collected block, runs the 64 rounds on a
   // copy of the chaining words and adds the result back in.
   function automatic void compress_into_chain();
      word_type sched [64];
      word_type v [8];
      word_type t1;
      word_type t2;
      for (int i = 0; i < 16; i++) begin
         sched[i] = block_words[i];
      end
      for (int i = 16; i < 64; i++) begin
         sched[i] = (rotr(sched[i-2], 17) ^ rotr(sched[i-2], 19) ^ (sched[i-2] >> 10))
                  + sched[i-7]
                  + (rotr(sched[i-15], 7) ^ rotr(sched[i-15], 18) ^ (sched[i-15] >> 3))
                  + sched[i-16];
      end
      v = chain_state;
      for (int i = 0; i < 64; i++) begin
         t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + sched[i];
         t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6];
         v[6] = v[5];
         v[5] = v[4];
         v[4] = v[3] + t1;
         v[3] = v[2];
         v[2] = v[1];
         v[1] = v[0];
         v[0] = t1 + t2;
      end
      for (int k = 0; k < 8; k++) begin
         chain_state[k] = chain_state[k] + v[k];
      end
   endfunction

   // Takes one accepted message word into the model. Returns 1 when the word
   // completes a final block, so the chaining words are now a digest.
   function automatic bit absorb_word(input word_type data, input logic first,
                                      input logic fin);
      if (word_pos == 4'd0) begin
         block_mode = {fin, first};
         if (first) begin
            chain_state = START_HASH;
         end
      end
      block_words[word_pos] = data;
      if (word_pos != 4'd15) begin
         word_pos = word_pos + 4'd1;
         return 1'b0;
      end
      word_pos = 4'd0;
      compress_into_chain();
      return block_mode[1];
   endfunction

   // Offers one word on the request channel, idling first at random, and
   // waits for it to be taken. The payload holds still while stalled. When
   // the word completes a final block, the eight digest words are queued,
   // either from the model or, for the known vector, as typed above.
   task automatic send_word(input word_type data, input logic first, input logic fin,
                            input logic known);
      digest_out_type entry;
      @(negedge clock);
      while (!steady_phase && $urandom_range(0, 99) < 17) begin
         req_valid        <= 1'b0;
         req_message_word <= $urandom();
         req_first_block  <= 1'($urandom_range(0, 1));
         req_final_block  <= 1'($urandom_range(0, 1));
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_message_word <= data;
      req_first_block  <= first;
      req_final_block  <= fin;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      words_accepted++;
      if (absorb_word(data, first, fin)) begin
         for (int k = 0; k < 8; k++) begin
            entry.digest    = known ? ABC_DIGEST[k] : chain_state[k];
            entry.index     = 3'(k);
            entry.last_flag = (k == 7);
            digest_expect_q.push_back(entry);
         end
         digests_expected++;
      end
   endtask

   // Result side. The stall is decided at the falling edge. Once two digests
   // have been taken, the next pending digest word is held off for a long
   // stretch while the sender keeps offering, so the block backs up and
   // stalls its input.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!long_hold_done && digests_seen == 2 && rsp_valid) begin
         hold_left      = LONG_HOLD - 1;
         long_hold_done = 1'b1;
         rsp_stall      <= 1'b1;
      end else if (steady_phase) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < 17);
      end
   end

   // Checks each accepted digest word against the oldest expectation, field
   // by field, and runs the watchdog on cycles where neither channel moves.
   always @(posedge clock) begin
      digest_out_type want;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (digest_expect_q.size() == 0) begin
               $display("%0t ns: unexpected digest word %h index %0d, none expected",
                        $time, rsp_digest_word, rsp_word_index);
               error_count++;
            end else begin
               want = digest_expect_q.pop_front();
               if (rsp_digest_word !== want.digest) begin
                  $display("%0t ns: digest word mismatch: expected %h, actual %h",
                           $time, want.digest, rsp_digest_word);
                  error_count++;
               end
               if (rsp_word_index !== want.index) begin
                  $display("%0t ns: word index mismatch: expected %0d, actual %0d",
                           $time, want.index, rsp_word_index);
                  error_count++;
               end
               if (rsp_last_word !== want.last_flag) begin
                  $display("%0t ns: last word flag mismatch: expected %b, actual %b",
                           $time, want.last_flag, rsp_last_word);
                  error_count++;
               end
               results_checked++;
               if (want.last_flag) begin
                  digests_seen++;
               end
            end
         end
         if (idle_cycles == STALL_LIMIT) begin
            $display("%0t ns: no word moved for %0d cycles, %0d digest words outstanding",
                     $time, STALL_LIMIT, digest_expect_q.size());
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      int       blk;
      logic     first;
      logic     fin;
      word_type data;

      chain_state = START_HASH;
      word_pos    = 4'd0;
      block_mode  = 2'b00;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table first.
      foreach (DIRECTED_ROWS[r]) begin
         send_word(DIRECTED_ROWS[r].data, DIRECTED_ROWS[r].first, DIRECTED_ROWS[r].fin,
                   DIRECTED_ROWS[r].known);
      end

      // Random messages. Flags are drawn on word 0 of each block and are
      // noise on the others. Most blocks are final so digests are frequent;
      // the block before the pause and the very last block are always final.
      first = 1'b0;
      fin   = 1'b0;
      while (words_accepted < TOTAL_WORDS) begin
         blk = words_accepted / 16;
         if (words_accepted % 16 == 0) begin
            if (blk == PAUSE_BLOCK) begin
               // Hold the request side quiet until every digest is back.
               @(negedge clock);
               req_valid <= 1'b0;
               while (digest_expect_q.size() != 0) begin
                  @(negedge clock);
               end
            end
            steady_phase = (blk >= 13 && blk <= 15);
            first = 1'($urandom_range(0, 1));
            fin   = ($urandom_range(0, 2) != 0) || blk == PAUSE_BLOCK - 1
                    || blk == TOTAL_WORDS / 16 - 1;
         end else if (words_accepted % 16 == 1) begin
            first = 1'($urandom_range(0, 1));
            fin   = 1'($urandom_range(0, 1));
         end
         case ($urandom_range(0, 7))
            0:       data = 32'h00000000;
            1:       data = 32'hffffffff;
            2:       data = 32'h1 << $urandom_range(0, 31);
            default: data = $urandom();
         endcase
         send_word(data, first, fin, 1'b0);
      end
      steady_phase = 1'b0;

      @(negedge clock);
      req_valid <= 1'b0;
      while (digest_expect_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d message words (%0d blocks); %0d digests, %0d digest words checked.",
               words_accepted, words_accepted / 16, digests_seen, results_checked);
      $display("Covered the abc vector, chaining, reloads, a long hold, a pause; %0d mismatches.",
               error_count);
      if (error_count == 0 && digests_seen == digests_expected) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
